// ===== rtl/core/enms_pkg.sv =====
// Shared types and constants of the edge non-maximum suppression core.
package enms_pkg;

  localparam int ANGLE_BITS = 14;
  localparam int ROW_BITS   = 12;
  localparam int COL_BITS   = 10;
  localparam int WREG_BITS  = 11;
  localparam int HREG_BITS  = 13;
  localparam int CFG_BITS   = 13;

  // Angles are in sixteenths of a degree.
  localparam logic [ANGLE_BITS-1:0] DEG180   = 14'd2880;
  localparam logic [ANGLE_BITS-1:0] BOUND_A  = 14'd360;
  localparam logic [ANGLE_BITS-1:0] BOUND_B  = 14'd1080;
  localparam logic [ANGLE_BITS-1:0] BOUND_C  = 14'd1800;
  localparam logic [ANGLE_BITS-1:0] BOUND_D  = 14'd2520;

  localparam logic [WREG_BITS-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [HREG_BITS-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [HREG_BITS-1:0] HEIGHT_MAX   = 13'd4096;

  typedef enum logic [1:0] {
    SECT_0   = 2'd0,
    SECT_45  = 2'd1,
    SECT_90  = 2'd2,
    SECT_135 = 2'd3
  } sector_t;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_index_t;

endpackage

// ===== rtl/core/enms_if.sv =====
// Stream interfaces for gradient pixel requests and suppression results.
interface enms_pixel_if
  import enms_pkg::*;
#(
  parameter int MAG_BITS = 16
) ();
  logic                  valid;
  logic                  ready;
  logic [MAG_BITS-1:0]   magnitude;
  logic [ANGLE_BITS-1:0] angle;
  logic                  frame_start;

  modport source (output valid, magnitude, angle, frame_start, input ready);
  modport sink   (input valid, magnitude, angle, frame_start, output ready);
endinterface

interface enms_result_if
  import enms_pkg::*;
#(
  parameter int MAG_BITS = 16
) ();
  logic                valid;
  logic                ready;
  logic [ROW_BITS-1:0] out_row;
  logic [COL_BITS-1:0] out_col;
  logic [MAG_BITS-1:0] kept_magnitude;
  logic                frame_last;

  modport source (output valid, out_row, out_col, kept_magnitude, frame_last, input ready);
  modport sink   (input valid, out_row, out_col, kept_magnitude, frame_last, output ready);
endinterface

// ===== rtl/core/enms_sector.sv =====
// Angle folding and quantization into one of four gradient directions.
module enms_sector
  import enms_pkg::*;
(
  input  logic [ANGLE_BITS-1:0] angle,
  output sector_t               sector
);

  localparam logic [ANGLE_BITS-1:0] FOLD2 = 14'(2 * DEG180);
  localparam logic [ANGLE_BITS-1:0] FOLD3 = 14'(3 * DEG180);
  localparam logic [ANGLE_BITS-1:0] FOLD4 = 14'(4 * DEG180);
  localparam logic [ANGLE_BITS-1:0] FOLD5 = 14'(5 * DEG180);

  logic [ANGLE_BITS-1:0] base;
  logic [ANGLE_BITS-1:0] folded;
  logic [ANGLE_BITS-1:0] t;

  // The fold count is known from fixed compares, so one subtract does the
  // work of the repeated subtraction. Zero stays at zero.
  always_comb begin
    base = angle - 14'd1;
    if (base >= FOLD5) begin
      folded = base - FOLD5;
    end else if (base >= FOLD4) begin
      folded = base - FOLD4;
    end else if (base >= FOLD3) begin
      folded = base - FOLD3;
    end else if (base >= FOLD2) begin
      folded = base - FOLD2;
    end else if (base >= DEG180) begin
      folded = base - DEG180;
    end else begin
      folded = base;
    end
    t = (angle == '0) ? '0 : folded + 14'd1;

    if (t < BOUND_A) begin
      sector = SECT_0;
    end else if (t < BOUND_B) begin
      sector = SECT_45;
    end else if (t < BOUND_C) begin
      sector = SECT_90;
    end else if (t < BOUND_D) begin
      sector = SECT_135;
    end else begin
      sector = SECT_0;
    end
  end

endmodule

// ===== rtl/core/enms_line_buf.sv =====
// Magnitude and sector line buffers with a registered read and write forwarding.
module enms_line_buf
  import enms_pkg::*;
#(
  parameter int MAG_BITS = 16,
  parameter int DEPTH    = 1024,
  parameter int AW       = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  logic [MAG_BITS-1:0] wr_mag,
  input  sector_t             wr_sector,
  output logic [MAG_BITS-1:0] col_upper,
  output logic [MAG_BITS-1:0] col_middle,
  output sector_t             col_sector
);

  logic [MAG_BITS-1:0] upper_mem [DEPTH];
  logic [MAG_BITS-1:0] middle_mem [DEPTH];
  sector_t             sector_mem [DEPTH];

  logic [MAG_BITS-1:0] rd_upper;
  logic [MAG_BITS-1:0] rd_middle;
  sector_t             rd_sector;

  logic                fwd;
  logic [MAG_BITS-1:0] fwd_upper;
  logic [MAG_BITS-1:0] fwd_middle;
  sector_t             fwd_sector;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr]  <= col_middle;
      middle_mem[wr_addr] <= wr_mag;
      sector_mem[wr_addr] <= wr_sector;
    end
    if (rd_en) begin
      rd_upper  <= upper_mem[rd_addr];
      rd_middle <= middle_mem[rd_addr];
      rd_sector <= sector_mem[rd_addr];
    end
  end

  // A read that meets a write to the same column in one cycle sees old data,
  // so the written column is kept aside and used instead.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (rd_en) begin
      fwd <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_upper  <= col_middle;
      fwd_middle <= wr_mag;
      fwd_sector <= wr_sector;
    end
  end

  assign col_upper  = fwd ? fwd_upper  : rd_upper;
  assign col_middle = fwd ? fwd_middle : rd_middle;
  assign col_sector = fwd ? fwd_sector : rd_sector;

endmodule

// ===== rtl/core/enms_window.sv =====
// 3x3 magnitude window and the comparison along the gradient direction.
module enms_window
  import enms_pkg::*;
#(
  parameter int MAG_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic [MAG_BITS-1:0] col_upper,
  input  logic [MAG_BITS-1:0] col_middle,
  input  logic [MAG_BITS-1:0] col_mag,
  input  sector_t             col_sector,
  output logic [MAG_BITS-1:0] peak
);

  // Only the left and centre columns are held; the new right column comes from
  // the line buffers and the input stage, and the left column is win_col1.
  logic [MAG_BITS-1:0] win_col1 [3];
  logic [MAG_BITS-1:0] win_col2 [3];
  sector_t             centre_sector;

  logic [MAG_BITS-1:0] ctr;
  logic [MAG_BITS-1:0] e1;
  logic [MAG_BITS-1:0] e2;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        win_col1[i] <= '0;
        win_col2[i] <= '0;
      end
      centre_sector <= SECT_0;
    end else if (advance) begin
      for (int i = 0; i < 3; i++) begin
        win_col1[i] <= win_col2[i];
      end
      win_col2[0]   <= col_upper;
      win_col2[1]   <= col_middle;
      win_col2[2]   <= col_mag;
      centre_sector <= col_sector;
    end
  end

  always_comb begin
    ctr = win_col2[1];
    case (centre_sector)
      SECT_45: begin
        e1 = win_col1[2];
        e2 = col_upper;
      end
      SECT_90: begin
        e1 = win_col2[2];
        e2 = win_col2[0];
      end
      SECT_135: begin
        e1 = win_col1[0];
        e2 = col_mag;
      end
      default: begin
        e1 = col_middle;
        e2 = win_col1[1];
      end
    endcase
    peak = (ctr >= e1 && ctr >= e2) ? ctr : '0;
  end

endmodule

// ===== rtl/core/edge_non_maximum_suppression_core.sv =====
// Streaming 3x3 non-maximum suppression: top level with counters and pipeline.
//
// Pixels of gradient magnitude and angle arrive in raster order, one request
// per clock at full rate while res.ready does not stall the result register,
// and the result for centre pixel (r-1, c-1) leaves with the pixel (r, c)
// that completes its window; the last row and column are never reported. A
// pixel goes through an input stage, where the line buffers are read into
// registers, and the window compare loads the result register when that
// stage advances. The line buffers are not cleared after reset: start each
// stream with frame_start so that stale entries only reach results that are
// forced to zero. Width and height are clamped to their supported ranges and
// should be written while the block is idle.
module edge_non_maximum_suppression_core
  import enms_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int MAG_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  enms_pixel_if.sink           pix,
  enms_result_if.source        res,
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_index,
  input  logic [CFG_BITS-1:0]  cfg_data
);

  localparam int AW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WLIM = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

  // Configuration registers and their clamped values.
  logic [WREG_BITS-1:0] frame_width;
  logic [HREG_BITS-1:0] frame_height;
  logic [WREG_BITS-1:0] w_eff;
  logic [HREG_BITS-1:0] h_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[WREG_BITS-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[HREG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width < 11'd3) begin
      w_eff = 11'd3;
    end else if (frame_width > 11'(WLIM)) begin
      w_eff = 11'(WLIM);
    end else begin
      w_eff = frame_width;
    end
    if (frame_height < 13'd3) begin
      h_eff = 13'd3;
    end else if (frame_height > HEIGHT_MAX) begin
      h_eff = HEIGHT_MAX;
    end else begin
      h_eff = frame_height;
    end
  end

  // Handshake and pipeline control.
  logic in_fire;
  logic in_ready;
  logic a_valid;
  logic a_go;
  logic o_valid;

  assign in_fire   = pix.valid && in_ready;
  assign a_go      = a_valid && (!o_valid || res.ready);
  assign in_ready  = !a_valid || a_go;
  assign pix.ready = in_ready;

  // Position counters.
  logic [ROW_BITS-1:0] row_count;
  logic [COL_BITS-1:0] col_count;
  logic [ROW_BITS-1:0] cur_row;
  logic [COL_BITS-1:0] cur_col;
  logic [AW-1:0]       cur_idx;
  logic [HREG_BITS-1:0] row_inc;
  logic [WREG_BITS-1:0] col_inc;

  always_comb begin
    cur_row = pix.frame_start ? '0 : row_count;
    cur_col = pix.frame_start ? '0 : col_count;
    row_inc = {1'b0, cur_row} + 13'd1;
    col_inc = {1'b0, cur_col} + 11'd1;
    if ({4'd0, cur_col} > 14'(MAX_WIDTH - 1)) begin
      cur_idx = AW'(MAX_WIDTH - 1);
    end else begin
      cur_idx = AW'(cur_col);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (in_fire) begin
      if (col_inc >= w_eff) begin
        col_count <= '0;
        row_count <= (row_inc >= h_eff) ? '0 : row_inc[ROW_BITS-1:0];
      end else begin
        col_count <= col_inc[COL_BITS-1:0];
        row_count <= cur_row;
      end
    end
  end

  // Input stage.
  sector_t             in_sector;
  sector_t             a_sector;
  logic [MAG_BITS-1:0] a_mag;
  logic [ROW_BITS-1:0] a_row;
  logic [COL_BITS-1:0] a_col;
  logic [AW-1:0]       a_idx;

  enms_sector u_sector (
    .angle  (pix.angle),
    .sector (in_sector)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_fire) begin
      a_valid <= 1'b1;
    end else if (a_go) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_mag    <= pix.magnitude;
      a_sector <= in_sector;
      a_row    <= cur_row;
      a_col    <= cur_col;
      a_idx    <= cur_idx;
    end
  end

  logic [MAG_BITS-1:0] col_upper;
  logic [MAG_BITS-1:0] col_middle;
  sector_t             col_sector;
  logic [MAG_BITS-1:0] peak;

  enms_line_buf #(
    .MAG_BITS (MAG_BITS),
    .DEPTH    (MAX_WIDTH),
    .AW       (AW)
  ) u_line_buf (
    .clk        (clk),
    .rst        (rst),
    .rd_en      (in_fire),
    .rd_addr    (cur_idx),
    .wr_en      (a_go),
    .wr_addr    (a_idx),
    .wr_mag     (a_mag),
    .wr_sector  (a_sector),
    .col_upper  (col_upper),
    .col_middle (col_middle),
    .col_sector (col_sector)
  );

  enms_window #(
    .MAG_BITS (MAG_BITS)
  ) u_window (
    .clk        (clk),
    .rst        (rst),
    .advance    (a_go),
    .col_upper  (col_upper),
    .col_middle (col_middle),
    .col_mag    (a_mag),
    .col_sector (col_sector),
    .peak       (peak)
  );

  // Result register.
  logic                emit;
  logic                interior;
  logic [ROW_BITS-1:0] rr;
  logic [COL_BITS-1:0] cc;
  logic                is_last;
  logic [ROW_BITS-1:0] o_row;
  logic [COL_BITS-1:0] o_col;
  logic [MAG_BITS-1:0] o_kept;
  logic                o_last;

  always_comb begin
    emit     = (a_row != '0) && (a_col != '0);
    rr       = a_row - 12'd1;
    cc       = a_col - 10'd1;
    // Centres on the first row or column are always suppressed.
    interior = (rr != '0) && (cc != '0);
    is_last  = ({1'b0, rr} == (h_eff - 13'd2)) && ({1'b0, cc} == (w_eff - 11'd2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (a_go) begin
      o_valid <= emit;
    end else if (res.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go) begin
      o_row  <= rr;
      o_col  <= cc;
      o_kept <= interior ? peak : '0;
      o_last <= is_last;
    end
  end

  assign res.valid          = o_valid;
  assign res.out_row        = o_row;
  assign res.out_col        = o_col;
  assign res.kept_magnitude = o_kept;
  assign res.frame_last     = o_last;

  // Checks on the pipeline.
  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    pix.valid && pix.ready |=> a_valid)
    else $error("accepted pixel request did not reach the input stage");

  a_empty_stage_ready: assert property (@(posedge clk) disable iff (rst)
    !a_valid |-> pix.ready)
    else $error("input not ready while the input stage is empty");

  a_border_suppressed: assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.out_row == '0 || res.out_col == '0) |-> res.kept_magnitude == '0)
    else $error("border centre pixel was not suppressed");

  a_last_not_border: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.frame_last |-> res.out_row != '0 && res.out_col != '0)
    else $error("frame end flagged on a border pixel");

endmodule
